// ----- rtl/tsh_pkg.sv -----
// Package for the tail swing H-bridge PWM unit.
// Holds field widths, register addresses, reset values and shared types.
// No dependencies.
package tsh_pkg;

  localparam int unsigned PERIOD_W = 12;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned STEP_W   = 12;
  localparam int unsigned ANGLE_W  = 10;
  localparam int unsigned INTEN_W  = 9;
  localparam int unsigned CLIMB_W  = 11;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 32;

  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned TIMER_BITS_DEF = 12;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-1:0] REG_PERIOD_ADDR = 3'd0;
  localparam logic [APB_ADDR_W-1:0] REG_LIMIT_ADDR  = 3'd4;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 12'd350;
  localparam logic [DUTY_W-1:0]   LIMIT_RST  = 7'd30;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [DUTY_W-1:0]   limit;
  } tsh_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_THR,
    ST_CLIMB,
    ST_TERM,
    ST_CLAMP,
    ST_DUTY,
    ST_FIN
  } tsh_state_e;

endpackage

// ----- rtl/tsh_cfg.sv -----
// APB register file of the tail swing H-bridge PWM unit.
// Holds the swing period and the safe duty limit; depends on tsh_pkg.
module tsh_cfg
  import tsh_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output tsh_cfg_t              cfg_o
);

  logic [PERIOD_W-1:0] period_q;
  logic [DUTY_W-1:0]   limit_q;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      limit_q  <= LIMIT_RST;
    end else if (wr_en) begin
      case (paddr)
        REG_PERIOD_ADDR: period_q <= pwdata[PERIOD_W-1:0];
        REG_LIMIT_ADDR:  limit_q  <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_PERIOD_ADDR: prdata = APB_DATA_W'(period_q);
      REG_LIMIT_ADDR:  prdata = APB_DATA_W'(limit_q);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.period = period_q;
  assign cfg_o.limit  = limit_q;

endmodule

// ----- rtl/tsh_mul.sv -----
// Shared signed multiplier with a registered product.
// Used by the sequencer of the tail swing unit; depends on tsh_pkg.
module tsh_mul
  import tsh_pkg::*;
#(
  parameter int unsigned A_W = 13,
  parameter int unsigned B_W = 13
) (
  input  logic                     clk_i,
  input  logic signed [A_W-1:0]    a_i,
  input  logic signed [B_W-1:0]    b_i,
  output logic signed [A_W+B_W-1:0] p_o
);

  logic signed [A_W+B_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- rtl/tail_swing_hbridge_pwm_unit.sv -----
// Tail swing and climb H-bridge PWM unit: top level with the sequencer.
// A request steps through the states THR, CLIMB, TERM, CLAMP, DUTY and FIN; its result is registered as it leaves FIN.
// A new request is taken only in IDLE, once the last one has left FIN; the shared multiplier is used four times
// per request, and an earlier result still waiting at the output holds the last step.
// The input side is ready again while a finished result waits at the output.
// Reset is asynchronous and active low; the swing timer is cleared and idle.
module tail_swing_hbridge_pwm_unit
  import tsh_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // step_ticks[11:0], swing_angle[21:12], swing_intensity[30:22],
  // climb_speed[41:31], zero padding [47:42]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tail_forward_duty[6:0], tail_reverse_duty[13:7], climb_up_duty[20:14],
  // climb_down_duty[27:21], swing_phase[28], duty_saturated[29], zeros [31:30]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned MA_W   = PERIOD_W + 1;
  localparam int unsigned MB_W   = ((FRAC_BITS + 3 > 11) ? FRAC_BITS + 3 : 11) + 2;
  localparam int unsigned PROD_W = MA_W + MB_W;
  localparam int unsigned SUM_W  = ((TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W) + 1;
  localparam int unsigned LHS_W  = TIMER_BITS + 4 + FRAC_BITS;
  localparam int unsigned CMP_W  = ((LHS_W > PROD_W) ? LHS_W : PROD_W) + 1;
  localparam int unsigned SH_W   = PROD_W - FRAC_BITS;
  localparam logic [MB_W-1:0]      ONE_B  = MB_W'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0]   ONE_T  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [SH_W-1:0]      ONE_SH = SH_W'(1) << FRAC_BITS;

  tsh_cfg_t cfg;

  tsh_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tsh_state_e state_q, state_d;

  logic [TIMER_BITS-1:0]     timer_q, timer_d;
  logic                      running_q;
  logic [DUTY_W-1:0]         held_fwd_q, held_rev_q;
  logic                      phase_q;
  logic                      m_valid_q;
  logic [OUT_DATA_W-1:0]     m_data_q, m_data_d;

  logic [ANGLE_W-1:0]        angle_q;
  logic [INTEN_W-1:0]        inten_q;
  logic [CLIMB_W-1:0]        climb_q;
  logic [FRAC_BITS:0]        term_q, term_d;
  logic [DUTY_W-1:0]         up_q, down_q, up_d, down_d;
  logic                      sat_q, sat_d;

  logic                      accept, out_free, fin_go;
  logic [PERIOD_W-1:0]       period_eff, step_in, step_c;
  logic [SUM_W-1:0]          sum, wrap;

  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic [MB_W-1:0]           angle_ext, one_plus, one_minus, thr_fac;
  logic [MA_W-1:0]           period_a, climb_a, inten_a, lim_a;
  logic [MB_W-1:0]           lim_b, term_b;
  logic [CLIMB_W-1:0]        climb_abs;
  logic [TIMER_BITS+3:0]     timer10;
  logic [CMP_W-1:0]          lhs_ext, thr_ext;
  logic                      phase_d;
  logic [SH_W-1:0]           prod_sh, lim_sh;
  logic [DUTY_W-1:0]         duty, fwd_out, rev_out;
  logic                      inten_zero;

  tsh_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign fin_go        = (state_q == ST_FIN) && out_free;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Timer update in the accept cycle.
  assign period_eff = (cfg.period == '0) ? PERIOD_W'(1) : cfg.period;
  assign step_in    = s_axis_tdata[STEP_W-1:0];
  assign step_c     = (step_in > period_eff) ? period_eff : step_in;
  assign sum        = (running_q ? SUM_W'(timer_q) : '0) + SUM_W'(step_c);
  assign wrap       = (sum >= SUM_W'(period_eff)) ? sum - SUM_W'(period_eff) : sum;
  assign timer_d    = (s_axis_tdata[30:22] == '0) ? '0 : wrap[TIMER_BITS-1:0];

  // Multiplier operands.
  assign angle_ext = {{(MB_W-ANGLE_W){angle_q[ANGLE_W-1]}}, angle_q};
  assign one_plus  = ONE_B + angle_ext;
  assign one_minus = ONE_B - angle_ext;
  assign thr_fac   = (ONE_B << 2) + ONE_B + (angle_ext << 2);
  assign climb_abs = climb_q[CLIMB_W-1] ? (~climb_q + CLIMB_W'(1)) : climb_q;
  assign period_a  = MA_W'(period_eff);
  assign climb_a   = MA_W'(climb_abs);
  assign inten_a   = MA_W'(inten_q);
  assign lim_a     = MA_W'(cfg.limit);
  assign lim_b     = MB_W'(cfg.limit);
  assign term_b    = MB_W'(term_q);

  always_comb begin
    state_d = state_q;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_THR;
        end
      end
      ST_THR: begin
        mul_a   = period_a;
        mul_b   = thr_fac;
        state_d = ST_CLIMB;
      end
      ST_CLIMB: begin
        mul_a   = climb_a;
        mul_b   = lim_b;
        state_d = ST_TERM;
      end
      ST_TERM: begin
        mul_a   = inten_a;
        mul_b   = phase_q ? one_minus : one_plus;
        state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        state_d = ST_DUTY;
      end
      ST_DUTY: begin
        mul_a   = lim_a;
        mul_b   = term_b;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        mul_a = lim_a;
        mul_b = term_b;
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Forward part test: timer * 10 * ONE against the registered threshold.
  assign timer10 = {1'b0, timer_q, 3'b000} + {3'b000, timer_q, 1'b0};
  assign lhs_ext = CMP_W'({timer10, {FRAC_BITS{1'b0}}});
  assign thr_ext = {{(CMP_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign phase_d = !($signed(lhs_ext) < $signed(thr_ext));

  // Climb duty with clipping, and the swing term clamp.
  assign prod_sh = prod[PROD_W-1:FRAC_BITS];
  assign lim_sh  = SH_W'(cfg.limit);
  assign sat_d   = (prod_sh > lim_sh);
  assign up_d    = (!climb_q[CLIMB_W-1] && climb_q != '0) ?
                   (sat_d ? cfg.limit : prod_sh[DUTY_W-1:0]) : '0;
  assign down_d  = climb_q[CLIMB_W-1] ? (sat_d ? cfg.limit : prod_sh[DUTY_W-1:0]) : '0;

  always_comb begin
    if (prod[PROD_W-1] || prod == '0) begin
      term_d = '0;
    end else if (prod_sh > ONE_SH) begin
      term_d = ONE_T;
    end else begin
      term_d = prod_sh[FRAC_BITS:0];
    end
  end

  // Result assembly.
  assign inten_zero = (inten_q == '0);
  assign duty       = prod[FRAC_BITS+DUTY_W-1:FRAC_BITS];
  assign fwd_out    = inten_zero ? held_fwd_q : (phase_q ? '0 : duty);
  assign rev_out    = inten_zero ? held_rev_q : (phase_q ? duty : '0);
  assign m_data_d   = OUT_DATA_W'({sat_q, phase_q && !inten_zero, down_q, up_q,
                                   rev_out, fwd_out});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      timer_q    <= '0;
      running_q  <= 1'b0;
      held_fwd_q <= '0;
      held_rev_q <= '0;
      phase_q    <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        timer_q   <= timer_d;
        running_q <= (s_axis_tdata[30:22] != '0);
      end
      if (state_q == ST_CLIMB) begin
        phase_q <= phase_d;
      end
      if (fin_go) begin
        m_valid_q <= 1'b1;
        if (!inten_zero) begin
          held_fwd_q <= fwd_out;
          held_rev_q <= rev_out;
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      angle_q <= s_axis_tdata[21:12];
      inten_q <= s_axis_tdata[30:22];
      climb_q <= s_axis_tdata[41:31];
    end
    if (state_q == ST_TERM) begin
      up_q   <= up_d;
      down_q <= down_d;
      sat_q  <= sat_d;
    end
    if (state_q == ST_CLAMP) begin
      term_q <= term_d;
    end
    if (fin_go) begin
      m_data_q <= m_data_d;
    end
  end

endmodule
